@@ sv/stt_pkg.sv @@
// stt_pkg: shared types, codes, byte constants and helper functions
// for the source text tokenizer; no dependencies
package stt_pkg;

    // position counter width and saturation value
    localparam int POS_BITS = 16;
    localparam int FIELD_BITS = 16;
    localparam int WIDE_BITS = 32;

    typedef logic [POS_BITS-1:0] t_pos;
    typedef logic [FIELD_BITS-1:0] t_field;

    localparam t_pos POS_MAX = {POS_BITS{1'b1}};

    // byte constants
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5a;
    localparam logic [7:0] CH_US    = 8'h5f;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7a;

    // scan modes
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_IDENT = 3'd1,
        MODE_INT   = 3'd2,
        MODE_STR   = 3'd3,
        MODE_EQ    = 3'd4,
        MODE_BANG  = 3'd5
    } t_mode;

    // token kinds
    typedef enum logic [4:0] {
        KIND_ILLEGAL  = 5'd0,
        KIND_EOF      = 5'd1,
        KIND_IDENT    = 5'd2,
        KIND_INT      = 5'd3,
        KIND_STRING   = 5'd4,
        KIND_ASSIGN   = 5'd5,
        KIND_EQUAL    = 5'd6,
        KIND_PLUS     = 5'd7,
        KIND_MINUS    = 5'd8,
        KIND_BANG     = 5'd9,
        KIND_NOTEQUAL = 5'd10,
        KIND_STAR     = 5'd11,
        KIND_SLASH    = 5'd12,
        KIND_LT       = 5'd13,
        KIND_GT       = 5'd14,
        KIND_SEMI     = 5'd15,
        KIND_COLON    = 5'd16,
        KIND_COMMA    = 5'd17,
        KIND_LPAREN   = 5'd18,
        KIND_RPAREN   = 5'd19,
        KIND_LBRACE   = 5'd20,
        KIND_RBRACE   = 5'd21,
        KIND_LBRACKET = 5'd22,
        KIND_RBRACKET = 5'd23
    } t_kind;

    // one token as it leaves the block
    typedef struct packed {
        t_kind  kind;
        t_field start;
        t_field length;
    } t_token;

    // tokens caused by one byte: one or two
    typedef struct packed {
        t_token tok0;
        t_token tok1;
        logic   two;
    } t_step_rec;

    // queue status toward the back end
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    localparam int Q_DEPTH = 4;
    localparam int Q_IDX_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) || c == CH_US;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic t_pos sat_inc(input t_pos p);
        return (p == POS_MAX) ? p : p + t_pos'(1);
    endfunction

    function automatic t_pos span(input t_pos from, input t_pos to);
        return (to >= from) ? to - from : '0;
    endfunction

    // low field bits of a position value
    function automatic t_field to_field(input t_pos v);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(v);
        return w[FIELD_BITS-1:0];
    endfunction

    function automatic t_token mk_tok(input t_kind k, input t_pos s, input t_pos len);
        t_token t;
        t.kind = k;
        t.start = to_field(s);
        t.length = to_field(len);
        return t;
    endfunction

    // single character operators and brackets
    function automatic t_kind single_kind(input logic [7:0] c);
        t_kind k;
        unique case (c)
            8'h2b:   k = KIND_PLUS;
            8'h2d:   k = KIND_MINUS;
            8'h2a:   k = KIND_STAR;
            8'h2f:   k = KIND_SLASH;
            8'h3c:   k = KIND_LT;
            8'h3e:   k = KIND_GT;
            8'h3b:   k = KIND_SEMI;
            8'h3a:   k = KIND_COLON;
            8'h2c:   k = KIND_COMMA;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7b:   k = KIND_LBRACE;
            8'h7d:   k = KIND_RBRACE;
            8'h5b:   k = KIND_LBRACKET;
            8'h5d:   k = KIND_RBRACKET;
            default: k = KIND_ILLEGAL;
        endcase
        return k;
    endfunction

endpackage

@@ sv/stt_ifs.sv @@
// stt_ifs: valid/ready channel interfaces for source bytes and tokens
// depends on stt_pkg
interface stt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] next_byte;

    modport source (output valid, output next_byte, input ready);
    modport sink (input valid, input next_byte, output ready);
endinterface

interface stt_tok_if;
    logic                valid;
    logic                ready;
    stt_pkg::t_kind      token_kind;
    stt_pkg::t_field     token_start;
    stt_pkg::t_field     token_length;
    logic                last_of_step;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output last_of_step, input ready);
    modport sink (input valid, input token_kind, input token_start,
                  input token_length, input last_of_step, output ready);
endinterface

@@ sv/stt_front.sv @@
// stt_front: accepts source bytes, tracks scan mode and positions, and
// builds the token record for each byte; depends on stt_pkg, stt_ifs
module stt_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    stt_byte_if.sink           i_src,
    input  stt_pkg::t_q_stat   i_q_stat,
    output logic               o_push,
    output stt_pkg::t_step_rec o_rec
);
    import stt_pkg::*;

    t_mode r_mode, n_mode;
    t_pos  r_begin, n_begin;
    t_pos  r_pos, n_pos;

    logic [7:0] c;
    logic       acc;

    // idle scan of the byte
    logic   idle_emit;
    t_token idle_tok;
    t_mode  idle_mode;
    logic   idle_set;
    t_pos   idle_beg;

    // token closed by the byte in the current mode
    logic   pre_emit;
    t_token pre_tok;
    logic   use_idle;
    logic   stay;

    assign c = i_src.next_byte;
    assign i_src.ready = !i_q_stat.full;
    assign acc = i_src.valid && i_src.ready;

    // byte scanned as if between tokens
    always_comb begin
        idle_emit = 1'b0;
        idle_tok = mk_tok(KIND_ILLEGAL, r_pos, t_pos'(1));
        idle_mode = MODE_IDLE;
        idle_set = 1'b0;
        idle_beg = r_pos;
        if (is_space(c)) begin
            idle_emit = 1'b0;
        end else if (c == CH_NUL) begin
            idle_emit = 1'b1;
            idle_tok = mk_tok(KIND_EOF, r_pos, '0);
        end else if (is_letter(c)) begin
            idle_mode = MODE_IDENT;
            idle_set = 1'b1;
        end else if (is_digit(c)) begin
            idle_mode = MODE_INT;
            idle_set = 1'b1;
        end else if (c == CH_QUOTE) begin
            idle_mode = MODE_STR;
            idle_set = 1'b1;
            idle_beg = sat_inc(r_pos);
        end else if (c == CH_EQ) begin
            idle_mode = MODE_EQ;
            idle_set = 1'b1;
        end else if (c == CH_BANG) begin
            idle_mode = MODE_BANG;
            idle_set = 1'b1;
        end else begin
            idle_emit = 1'b1;
            idle_tok = mk_tok(single_kind(c), r_pos, t_pos'(1));
        end
    end

    // continue or close the token in progress
    always_comb begin
        pre_emit = 1'b0;
        pre_tok = mk_tok(KIND_IDENT, r_begin, span(r_begin, r_pos));
        use_idle = 1'b0;
        stay = 1'b0;
        unique case (r_mode)
            MODE_IDENT: begin
                if (is_letter(c) || is_digit(c)) begin
                    stay = 1'b1;
                end else begin
                    pre_emit = 1'b1;
                    use_idle = 1'b1;
                end
            end
            MODE_INT: begin
                pre_tok.kind = KIND_INT;
                if (is_digit(c)) begin
                    stay = 1'b1;
                end else begin
                    pre_emit = 1'b1;
                    use_idle = 1'b1;
                end
            end
            MODE_STR: begin
                pre_tok.kind = KIND_STRING;
                if (c == CH_QUOTE) begin
                    pre_emit = 1'b1;
                end else if (c == CH_NUL) begin
                    pre_emit = 1'b1;
                    use_idle = 1'b1;
                end else begin
                    stay = 1'b1;
                end
            end
            MODE_EQ: begin
                pre_emit = 1'b1;
                if (c == CH_EQ) begin
                    pre_tok = mk_tok(KIND_EQUAL, r_begin, t_pos'(2));
                end else begin
                    pre_tok = mk_tok(KIND_ASSIGN, r_begin, t_pos'(1));
                    use_idle = 1'b1;
                end
            end
            MODE_BANG: begin
                pre_emit = 1'b1;
                if (c == CH_EQ) begin
                    pre_tok = mk_tok(KIND_NOTEQUAL, r_begin, t_pos'(2));
                end else begin
                    pre_tok = mk_tok(KIND_BANG, r_begin, t_pos'(1));
                    use_idle = 1'b1;
                end
            end
            default: begin
                use_idle = 1'b1;
            end
        endcase
    end

    // next state, end of source restarts positions
    always_comb begin
        if (use_idle) begin
            n_mode = idle_mode;
        end else if (stay) begin
            n_mode = r_mode;
        end else begin
            n_mode = MODE_IDLE;
        end
        n_begin = (use_idle && idle_set) ? idle_beg : r_begin;
        n_pos = sat_inc(r_pos);
        if (c == CH_NUL) begin
            n_mode = MODE_IDLE;
            n_begin = '0;
            n_pos = '0;
        end
    end

    // record pushed into the queue
    always_comb begin
        o_rec.tok0 = pre_emit ? pre_tok : idle_tok;
        o_rec.tok1 = idle_tok;
        o_rec.two = pre_emit && use_idle && idle_emit;
        o_push = acc && (pre_emit || (use_idle && idle_emit));
    end

    // scan state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_begin <= '0;
            r_pos <= '0;
        end else if (acc) begin
            r_mode <= n_mode;
            r_begin <= n_begin;
            r_pos <= n_pos;
        end
    end

endmodule

@@ sv/stt_queue.sv @@
// stt_queue: short queue of per-byte token records between front and back
// depends on stt_pkg
module stt_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  stt_pkg::t_step_rec i_rec,
    input  logic               i_pop,
    output stt_pkg::t_step_rec o_rec,
    output stt_pkg::t_q_stat   o_stat
);
    import stt_pkg::*;

    t_step_rec r_mem [Q_DEPTH];
    logic [Q_IDX_BITS-1:0] r_wr, r_rd;
    logic [Q_CNT_BITS-1:0] r_cnt;
    logic do_push, do_pop;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full = (r_cnt == Q_CNT_BITS'(Q_DEPTH));
    assign do_push = i_push && !o_stat.full;
    assign do_pop = i_pop && !o_stat.empty;
    assign o_rec = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + Q_IDX_BITS'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + Q_IDX_BITS'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + Q_CNT_BITS'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - Q_CNT_BITS'(1);
            end
        end
    end

endmodule

@@ sv/stt_back.sv @@
// stt_back: output register that serves the tokens of each record in order
// depends on stt_pkg, stt_ifs
module stt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stt_pkg::t_step_rec i_rec,
    input  stt_pkg::t_q_stat   i_q_stat,
    output logic               o_pop,
    stt_tok_if.source          o_tok
);
    import stt_pkg::*;

    t_step_rec r_rec;
    logic      r_valid;
    logic      r_idx;
    logic      last;
    logic      take;
    t_token    cur;

    assign last = !r_rec.two || r_idx;
    assign take = o_tok.valid && o_tok.ready;
    assign o_pop = !i_q_stat.empty && (!r_valid || (take && last));
    assign cur = r_idx ? r_rec.tok1 : r_rec.tok0;

    assign o_tok.valid = r_valid;
    assign o_tok.token_kind = cur.kind;
    assign o_tok.token_start = cur.start;
    assign o_tok.token_length = cur.length;
    assign o_tok.last_of_step = last;

    // record payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
        end
    end

    // valid and token index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_idx <= 1'b0;
        end else if (take) begin
            if (last) begin
                r_valid <= 1'b0;
                r_idx <= 1'b0;
            end else begin
                r_idx <= 1'b1;
            end
        end
    end

endmodule

@@ sv/source_text_tokenizer_unit.sv @@
// source_text_tokenizer_unit: top level of the streaming tokenizer
// depends on stt_pkg, stt_ifs, stt_front, stt_queue, stt_back
//
//  channel  dir  fields                                           handshake
//  i_src    in   next_byte[7:0]                                   valid/ready
//  o_tok    out  token_kind[4:0] token_start[15:0]                valid/ready
//                token_length[15:0] last_of_step
//
// one byte is taken per cycle while the four-record queue has room; the
// scan state updates in that same cycle, so bytes follow back to back
// a token passes through the queue storage and then the output register;
// the output register delivers one token per cycle while o_tok is ready,
// so the queue absorbs the bursts from bytes that end two tokens
// reset is synchronous and clears scan state, queue pointers and output valid
// a stalled output fills the queue, then input ready drops
module source_text_tokenizer_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stt_byte_if.sink  i_src,
    stt_tok_if.source o_tok
);
    import stt_pkg::*;

    logic      push, pop;
    t_step_rec front_rec, q_rec;
    t_q_stat   q_stat;

    stt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_src    (i_src),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_rec    (front_rec)
    );

    stt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .i_pop   (pop),
        .o_rec   (q_rec),
        .o_stat  (q_stat)
    );

    stt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rec    (q_rec),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_tok    (o_tok)
    );

endmodule

@@ sv/stt_checker.sv @@
// stt_checker: port level checks of the tokenizer, bound to the top level
// depends on stt_pkg
module stt_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input stt_pkg::t_kind  i_kind,
    input stt_pkg::t_field i_start,
    input stt_pkg::t_field i_length,
    input logic            i_last
);
    import stt_pkg::*;

    // a stalled token holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind)
            && $stable(i_start) && $stable(i_length) && $stable(i_last))
        else $error("stalled token changed");

    // end of file is empty and always closes its byte
    a_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_EOF |-> i_length == '0 && i_last)
        else $error("bad eof token");

    // two character operators
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == KIND_EQUAL || i_kind == KIND_NOTEQUAL)
            |-> i_length == FIELD_BITS'(2) && i_last)
        else $error("bad two character operator");

    // nothing shows right after reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("token valid after reset");

endmodule

bind source_text_tokenizer_unit stt_checker u_stt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_tok.valid),
    .i_out_ready (o_tok.ready),
    .i_kind      (o_tok.token_kind),
    .i_start     (o_tok.token_start),
    .i_length    (o_tok.token_length),
    .i_last      (o_tok.last_of_step)
);

@@ test/tb_top.sv @@
// tb_top: random and directed test of the source text tokenizer over its
// byte and token channels, with a token mirror that predicts every result
// depends on stt_pkg, stt_ifs and source_text_tokenizer_unit
package tb_lex_pkg;
    import stt_pkg::*;

    // one token the block owes us
    typedef struct {
        t_kind  kind;
        t_field start;
        t_field length;
        logic   last;
    } t_due_token;

    class lex_mirror;
        t_mode      mode = MODE_IDLE;
        t_pos       tok_begin = '0;
        t_pos       at_pos = '0;
        t_due_token tokens_due[$];
        int         mismatches = 0;

        function bit is_word_start(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_US;
        endfunction

        function bit is_dec(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function t_pos next_pos(t_pos p);
            return (p == POS_MAX) ? p : p + 1'b1;
        endfunction

        function t_pos run_len(t_pos from, t_pos to);
            return (to >= from) ? t_pos'(to - from) : '0;
        endfunction

        function void add(t_kind kind, t_pos start, t_pos len);
            t_due_token t;
            t.kind = kind;
            t.start = t_field'(start);
            t.length = t_field'(len);
            t.last = 1'b0;
            tokens_due.push_back(t);
        endfunction

        // scan a byte as if between tokens
        function void scan_fresh(logic [7:0] c, t_pos p);
            t_kind k;
            mode = MODE_IDLE;
            if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) return;
            if (c == CH_NUL) begin
                add(KIND_EOF, p, '0);
            end else if (is_word_start(c)) begin
                mode = MODE_IDENT;
                tok_begin = p;
            end else if (is_dec(c)) begin
                mode = MODE_INT;
                tok_begin = p;
            end else if (c == CH_QUOTE) begin
                mode = MODE_STR;
                tok_begin = next_pos(p);
            end else if (c == CH_EQ) begin
                mode = MODE_EQ;
                tok_begin = p;
            end else if (c == CH_BANG) begin
                mode = MODE_BANG;
                tok_begin = p;
            end else begin
                case (c)
                    "+": k = KIND_PLUS;
                    "-": k = KIND_MINUS;
                    "*": k = KIND_STAR;
                    "/": k = KIND_SLASH;
                    "<": k = KIND_LT;
                    ">": k = KIND_GT;
                    ";": k = KIND_SEMI;
                    ":": k = KIND_COLON;
                    ",": k = KIND_COMMA;
                    "(": k = KIND_LPAREN;
                    ")": k = KIND_RPAREN;
                    "{": k = KIND_LBRACE;
                    "}": k = KIND_RBRACE;
                    "[": k = KIND_LBRACKET;
                    "]": k = KIND_RBRACKET;
                    default: k = KIND_ILLEGAL;
                endcase
                add(k, p, t_pos'(1));
            end
        endfunction

        // accepted source byte: advance the scan and queue the tokens it ends
        function void take_byte(logic [7:0] c);
            t_pos p;
            int   first;
            p = at_pos;
            first = tokens_due.size();
            case (mode)
                MODE_IDENT: begin
                    if (!(is_word_start(c) || is_dec(c))) begin
                        add(KIND_IDENT, tok_begin, run_len(tok_begin, p));
                        scan_fresh(c, p);
                    end
                end
                MODE_INT: begin
                    if (!is_dec(c)) begin
                        add(KIND_INT, tok_begin, run_len(tok_begin, p));
                        scan_fresh(c, p);
                    end
                end
                MODE_STR: begin
                    if (c == CH_QUOTE) begin
                        add(KIND_STRING, tok_begin, run_len(tok_begin, p));
                        mode = MODE_IDLE;
                    end else if (c == CH_NUL) begin
                        add(KIND_STRING, tok_begin, run_len(tok_begin, p));
                        scan_fresh(c, p);
                    end
                end
                MODE_EQ: begin
                    if (c == CH_EQ) begin
                        add(KIND_EQUAL, tok_begin, t_pos'(2));
                        mode = MODE_IDLE;
                    end else begin
                        add(KIND_ASSIGN, tok_begin, t_pos'(1));
                        scan_fresh(c, p);
                    end
                end
                MODE_BANG: begin
                    if (c == CH_EQ) begin
                        add(KIND_NOTEQUAL, tok_begin, t_pos'(2));
                        mode = MODE_IDLE;
                    end else begin
                        add(KIND_BANG, tok_begin, t_pos'(1));
                        scan_fresh(c, p);
                    end
                end
                default: scan_fresh(c, p);
            endcase

            // end of source restarts positions for the next one
            if (c == CH_NUL) begin
                mode = MODE_IDLE;
                tok_begin = '0;
                at_pos = '0;
            end else begin
                at_pos = next_pos(p);
            end
            if (tokens_due.size() > first) tokens_due[$].last = 1'b1;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 30) $display("%0t %s", $time, msg);
        endfunction

        // accepted token: compare with the oldest one owed
        function void match_token(t_kind kind, t_field start, t_field length, logic last);
            t_due_token want;
            if (tokens_due.size() == 0) begin
                report($sformatf("unexpected token kind=%0d start=%0d length=%0d last=%0b",
                                 kind, start, length, last));
                return;
            end
            want = tokens_due.pop_front();
            if (kind !== want.kind || start !== want.start || length !== want.length ||
                last !== want.last) begin
                report($sformatf("token mismatch expected kind=%0d start=%0d length=%0d last=%0b %s",
                                 want.kind, want.start, want.length, want.last,
                                 $sformatf("actual kind=%0d start=%0d length=%0d last=%0b",
                                           kind, start, length, last)));
            end
        endfunction
    endclass
endpackage

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;
    import tb_lex_pkg::*;

    localparam int RANDOM_ITEMS = 1350;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_SELDOM, RX_PERIODIC} t_rx_style;

    logic i_clk = 1'b0;
    logic i_rst_n;

    stt_byte_if src_ch ();
    stt_tok_if  tok_ch ();

    source_text_tokenizer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src_ch),
        .o_tok   (tok_ch)
    );

    lex_mirror  mirror = new();
    logic [7:0] src_text[$];
    logic [7:0] blanks[4] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
    string      op_chars = "+-*/<>;:,(){}[]=!";
    int         bytes_in = 0;
    int         quiet_cycles = 0;
    logic       hold_off = 1'b0;
    t_rx_style  rx_style = RX_OPEN;
    int         rx_left = 0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] word_char(bit with_digits);
        int n;
        n = $urandom_range(0, with_digits ? 62 : 52);
        if (n < 26) return 8'(CH_LA + n);
        if (n < 52) return 8'(CH_UA + n - 26);
        if (n == 52) return CH_US;
        return 8'(CH_ZERO + n - 53);
    endfunction

    task automatic put_byte(logic [7:0] b);
        src_text.push_back(b);
    endtask

    task automatic put_text(string s);
        foreach (s[i]) src_text.push_back(s[i]);
    endtask

    // offer source bytes in bursts with random gaps
    task automatic feed_source();
        int burst;
        int gap;
        while (src_text.size() > 0) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && src_text.size() > 0) begin
                src_ch.valid <= 1'b1;
                src_ch.next_byte <= src_text.pop_front();
                @(posedge i_clk);
                while (!src_ch.ready) @(posedge i_clk);
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                src_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        src_ch.valid <= 1'b0;
    endtask

    // token receiver stalls in styles that change every so often
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_style <= t_rx_style'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            RX_OPEN:   tok_ch.ready <= !hold_off;
            RX_MOSTLY: tok_ch.ready <= !hold_off && ($urandom_range(0, 3) != 0);
            RX_SELDOM: tok_ch.ready <= !hold_off && ($urandom_range(0, 3) == 0);
            default:   tok_ch.ready <= !hold_off && (rx_left % 3 == 0);
        endcase
    end

    // one long hold-off on the token side so the block backs up
    initial begin
        wait (bytes_in >= 300);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // watch both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (src_ch.valid && src_ch.ready) begin
                mirror.take_byte(src_ch.next_byte);
                bytes_in <= bytes_in + 1;
            end
            if (tok_ch.valid && tok_ch.ready)
                mirror.match_token(tok_ch.token_kind, tok_ch.token_start,
                                   tok_ch.token_length, tok_ch.last_of_step);
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (src_ch.valid && src_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int         parts;
        int         pick;
        int         b;
        int         text_goal;
        logic [7:0] op;

        src_ch.valid = 1'b0;
        src_ch.next_byte = 8'h00;
        tok_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: letter and digit extremes, two-char operators, a token
        // ended by the next byte, strings, a high illegal byte, and a string
        // cut off by end of source
        put_text("_zA9");
        put_byte(CH_CR);
        put_text("90==!=!x");
        put_byte(CH_TAB);
        put_text("=\"ab\"");
        put_byte(8'hff);
        put_byte(CH_LF);
        put_text("\"q");
        put_byte(CH_NUL);

        // random sources built from mostly well-formed tokens
        text_goal = src_text.size() + RANDOM_ITEMS;
        while (src_text.size() < text_goal) begin
            parts = $urandom_range(0, 24);
            repeat (parts) begin
                pick = $urandom_range(0, 99);
                if (pick < 22) begin
                    put_byte(word_char(0));
                    repeat ($urandom_range(0, 7)) put_byte(word_char(1));
                end else if (pick < 34) begin
                    repeat ($urandom_range(1, 6)) put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
                end else if (pick < 46) begin
                    put_byte(CH_QUOTE);
                    repeat ($urandom_range(0, 6)) begin
                        b = $urandom_range(1, 254);
                        put_byte(8'((b >= CH_QUOTE) ? b + 1 : b));
                    end
                    put_byte(CH_QUOTE);
                end else if (pick < 92) begin
                    op = op_chars[$urandom_range(0, op_chars.len() - 1)];
                    put_byte(op);
                    if ((op == CH_EQ || op == CH_BANG) && $urandom_range(0, 1)) put_byte(CH_EQ);
                end else begin
                    put_byte(8'($urandom_range(1, 255)));
                end
                if ($urandom_range(0, 1)) put_byte(blanks[$urandom_range(0, 3)]);
            end
            // sometimes leave a string open at end of source
            if ($urandom_range(0, 5) == 0) begin
                put_byte(CH_QUOTE);
                repeat ($urandom_range(0, 3)) put_byte(word_char(1));
            end
            put_byte(CH_NUL);
        end

        feed_source();
        while (mirror.tokens_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mirror.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
